### hdl/dsf_pkg.sv
// Shared types and constants for the descendant set finder.
// Used by the sequencer, the top level, the checker and the testbench.
// No dependencies.
package dsf_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 32;
    localparam int SET_DEPTH   = TABLE_DEPTH + 1;
    localparam int ID_W        = 23;

    // Address and count widths
    localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int SAW = $clog2(SET_DEPTH);
    localparam int FCW = $clog2(SET_DEPTH + 1);

    // Stream widths: fields packed from the low end, padded to bytes
    localparam int TDATA_W = ((3 * ID_W + 7) / 8) * 8;
    localparam int MDATA_W = ((ID_W + 7) / 8) * 8;

    // Input kinds carried on tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // One table entry
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] parent;
    } t_pair;

    // Pair table port control
    typedef struct packed {
        logic           we;
        logic [TAW-1:0] waddr;
        t_pair          wdata;
        logic [TAW-1:0] raddr;
    } t_tbl_req;

    // Found set port control
    typedef struct packed {
        logic            we;
        logic [SAW-1:0]  waddr;
        logic [ID_W-1:0] wdata;
        logic [SAW-1:0]  raddr;
    } t_set_req;

endpackage

### hdl/dsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the pair table and the found set. No package dependency.
module dsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/dsf_ctrl.sv
// Sequencer for the descendant set finder: load handling, pass/scan walk
// over the pair table and found set RAMs, and the result output register.
// Depends on dsf_pkg.
module dsf_ctrl
    import dsf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,
    input  logic [0:0]         i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [MDATA_W-1:0] o_m_tdata,
    output logic               o_m_tlast,
    output logic [0:0]         o_m_tuser,
    output t_tbl_req           o_tbl_req,
    input  t_pair              i_tbl_rdata,
    output t_set_req           o_set_req,
    input  logic [ID_W-1:0]    i_set_rdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_pcnt,  n_pcnt;
    logic            r_ovf,   n_ovf;
    logic [FCW-1:0]  r_fcnt,  n_fcnt;
    logic [TAW-1:0]  r_i,     n_i;
    logic [SAW-1:0]  r_k,     n_k;
    logic            r_added, n_added;
    logic            r_phit,  n_phit;
    logic            r_ihit,  n_ihit;
    logic            r_mvalid, n_mvalid;
    logic [ID_W-1:0] r_mdata,  n_mdata;
    logic            r_mlast,  n_mlast;
    logic            r_muser,  n_muser;

    logic            in_xfer;
    logic            is_query;
    logic [ID_W-1:0] e_id, e_par, root;
    logic            out_free;
    logic            par_hit, id_hit, room, add;
    logic [FCW-1:0]  k_next;
    logic            scan_last, i_last;
    t_tbl_req        tbl_req;
    t_set_req        set_req;

    // Input field unpacking
    assign is_query = (i_s_tuser[0] == REQ_QUERY);
    assign e_id     = i_s_tdata[ID_W-1:0];
    assign e_par    = i_s_tdata[2*ID_W-1:ID_W];
    assign root     = i_s_tdata[3*ID_W-1:2*ID_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid & o_s_tready;
    assign out_free   = ~r_mvalid | i_m_tready;

    // Membership compare against the found set entry read this cycle
    assign par_hit   = r_phit | (i_set_rdata == i_tbl_rdata.parent);
    assign id_hit    = r_ihit | (i_set_rdata == i_tbl_rdata.id);
    assign room      = (r_fcnt < FCW'(SET_DEPTH));
    assign add       = par_hit & ~id_hit & room;
    assign k_next    = FCW'(r_k) + FCW'(1);
    assign scan_last = (k_next == r_fcnt);
    assign i_last    = ((CW'(r_i) + CW'(1)) == r_pcnt);

    // Next-state logic; RAM reads follow the next index so data lands
    // aligned with the registered index. A scan append never hits the found
    // set entry read in one cycle; the root write does, but that read is unused.
    always_comb begin
        n_state  = r_state;
        n_pcnt   = r_pcnt;
        n_ovf    = r_ovf;
        n_fcnt   = r_fcnt;
        n_i      = r_i;
        n_k      = r_k;
        n_added  = r_added;
        n_phit   = r_phit;
        n_ihit   = r_ihit;
        n_mvalid = r_mvalid & ~i_m_tready;
        n_mdata  = r_mdata;
        n_mlast  = r_mlast;
        n_muser  = r_muser;

        tbl_req.we           = 1'b0;
        tbl_req.waddr        = r_pcnt[TAW-1:0];
        tbl_req.wdata.id     = e_id;
        tbl_req.wdata.parent = e_par;
        set_req.we           = 1'b0;
        set_req.waddr        = r_fcnt[SAW-1:0];
        set_req.wdata        = i_tbl_rdata.id;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!is_query) begin
                        if (r_pcnt < CW'(TABLE_DEPTH)) begin
                            tbl_req.we = 1'b1;
                            n_pcnt     = r_pcnt + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        // root goes in as the first member
                        set_req.we    = 1'b1;
                        set_req.waddr = '0;
                        set_req.wdata = root;
                        n_fcnt        = FCW'(1);
                        n_i           = '0;
                        n_k           = '0;
                        n_added       = 1'b0;
                        n_state       = S_START;
                    end
                end
            end
            S_START: begin
                n_k    = '0;
                n_phit = 1'b0;
                n_ihit = 1'b0;
                n_state = (r_pcnt == '0) ? S_EMIT : S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) begin
                    if (add) begin
                        set_req.we = 1'b1;
                        n_fcnt     = r_fcnt + FCW'(1);
                    end
                    n_phit = 1'b0;
                    n_ihit = 1'b0;
                    n_k    = '0;
                    if (i_last) begin
                        n_i     = '0;
                        n_added = 1'b0;
                        if (!(r_added | add)) begin
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_i     = r_i + TAW'(1);
                        n_added = r_added | add;
                    end
                end else begin
                    n_k    = r_k + SAW'(1);
                    n_phit = par_hit;
                    n_ihit = id_hit;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_mvalid = 1'b1;
                    n_mdata  = i_set_rdata;
                    n_mlast  = scan_last;
                    n_muser  = r_ovf;
                    n_k      = r_k + SAW'(1);
                    if (scan_last) begin
                        n_pcnt  = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        tbl_req.raddr = n_i;
        set_req.raddr = n_k;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pcnt   <= '0;
            r_ovf    <= 1'b0;
            r_fcnt   <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_added  <= 1'b0;
            r_phit   <= 1'b0;
            r_ihit   <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pcnt   <= n_pcnt;
            r_ovf    <= n_ovf;
            r_fcnt   <= n_fcnt;
            r_i      <= n_i;
            r_k      <= n_k;
            r_added  <= n_added;
            r_phit   <= n_phit;
            r_ihit   <= n_ihit;
            r_mvalid <= n_mvalid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_mdata <= n_mdata;
        r_mlast <= n_mlast;
        r_muser <= n_muser;
    end

    assign o_tbl_req    = tbl_req;
    assign o_set_req    = set_req;
    assign o_m_tvalid   = r_mvalid;
    assign o_m_tdata    = MDATA_W'(r_mdata);
    assign o_m_tlast    = r_mlast;
    assign o_m_tuser[0] = r_muser;

endmodule

### hdl/descendant_set_finder_core.sv
// Load: taken back to back while no query runs. Query: root write, start state,
// passes that read found-set members one at a time (one RAM read port) for each
// table entry until a pass adds none, then one result per cycle unless stalled.
// Reset (i_rst_n low, synchronous) clears the table count, overflow flag,
// sequencer and output valid; RAM contents are left as they are, no sweep.
// Top level: pair table RAM, found set RAM and the sequencer (dsf_pkg).
module descendant_set_finder_core
    import dsf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,  // entry_id, entry_parent, root_id, pad
    input  logic [0:0]         i_s_axis_tuser,  // req_type
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [MDATA_W-1:0] o_m_axis_tdata,  // member_id, pad
    output logic               o_m_axis_tlast,  // last_member
    output logic [0:0]         o_m_axis_tuser   // table_overflowed
);

    t_tbl_req        tbl_req;
    t_pair           tbl_rdata;
    t_set_req        set_req;
    logic [ID_W-1:0] set_rdata;

    // Pair table
    dsf_ram #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (TABLE_DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_req.we),
        .i_waddr (tbl_req.waddr),
        .i_wdata (tbl_req.wdata),
        .i_raddr (tbl_req.raddr),
        .o_rdata (tbl_rdata)
    );

    // Found set
    dsf_ram #(
        .WIDTH (ID_W),
        .DEPTH (SET_DEPTH)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (set_req.we),
        .i_waddr (set_req.waddr),
        .i_wdata (set_req.wdata),
        .i_raddr (set_req.raddr),
        .o_rdata (set_rdata)
    );

    // Sequencer
    dsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast),
        .o_m_tuser   (o_m_axis_tuser),
        .o_tbl_req   (tbl_req),
        .i_tbl_rdata (tbl_rdata),
        .o_set_req   (set_req),
        .i_set_rdata (set_rdata)
    );

endmodule

### hdl/dsf_checker.sv
// Port-level checks for descendant_set_finder_core, attached by bind.
// Depends on dsf_pkg.
module dsf_checker
    import dsf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic [0:0]         i_s_axis_tuser,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [MDATA_W-1:0] o_m_axis_tdata,
    input logic               o_m_axis_tlast,
    input logic [0:0]         o_m_axis_tuser
);

    logic in_xfer;
    assign in_xfer = i_s_axis_tvalid & o_s_axis_tready;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // A query blocks further input on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_s_axis_tuser[0] == REQ_QUERY) |=> !o_s_axis_tready)
        else $error("input taken during query");

    // A load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_s_axis_tuser[0] == REQ_LOAD) && !o_m_axis_tvalid |=>
            !o_m_axis_tvalid)
        else $error("result after load");

    // Overflow flag is sticky across results
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |=> !o_m_axis_tvalid || o_m_axis_tuser[0])
        else $error("overflow flag dropped");

endmodule

bind descendant_set_finder_core dsf_checker u_dsf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### tb/tb.sv
// Self-checking testbench for descendant_set_finder_core: loads parent/child pairs,
// queries descendant sets and checks every member, tlast and overflow flag.
// Depends on dsf_pkg and the core; the expected sets come from a scoreboard class.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsf_pkg::*;

    localparam int ID_MAX       = 4194304;
    localparam int RANDOM_ITEMS = 100;
    localparam int QUIET_TAIL   = 20;
    localparam int STALL_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_MAX   = 10;

    typedef logic [ID_W-1:0] t_id;

    typedef struct packed {
        t_id  member;
        logic last;
        logic ovf;
    } t_member;

    // Scoreboard: keeps its own pair table and builds each descendant set
    class descendant_tracker;
        t_id         entry_ids[TABLE_DEPTH];
        t_id         entry_parents[TABLE_DEPTH];
        int          entry_total;
        bit          overflowed;
        t_id         set_ids[SET_DEPTH];
        int          set_total;
        t_member     pending_members[$];
        int          failures;

        function bit in_set(t_id v);
            for (int k = 0; k < set_total; k++)
                if (set_ids[k] == v) return 1'b1;
            return 1'b0;
        endfunction

        // Called once per accepted input transfer
        function void take_request(logic req, t_id id, t_id parent, t_id root);
            int      pass_base;
            t_member m;
            if (req == REQ_LOAD) begin
                if (entry_total < TABLE_DEPTH) begin
                    entry_ids[entry_total]     = id;
                    entry_parents[entry_total] = parent;
                    entry_total++;
                end else begin
                    overflowed = 1'b1;
                end
            end else begin
                set_ids[0] = root;
                set_total  = 1;
                // repeat passes in load order until one adds nothing
                do begin
                    pass_base = set_total;
                    for (int i = 0; i < entry_total; i++) begin
                        if (in_set(entry_parents[i]) && !in_set(entry_ids[i])
                            && set_total < SET_DEPTH) begin
                            set_ids[set_total] = entry_ids[i];
                            set_total++;
                        end
                    end
                end while (set_total != pass_base);
                for (int i = 0; i < set_total; i++) begin
                    m.member = set_ids[i];
                    m.last   = (i + 1 == set_total);
                    m.ovf    = overflowed;
                    pending_members.push_back(m);
                end
                entry_total = 0;
            end
        endfunction

        // Called once per accepted output transfer
        function void check_member(t_id member, logic last, logic ovf);
            t_member want;
            if (pending_members.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: member %0d last %0b overflow %0b",
                             member, last, ovf);
            end else begin
                want = pending_members.pop_front();
                if (want.member !== member || want.last !== last || want.ovf !== ovf) begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("mismatch: member exp %0d got %0d, last exp %0b got %0b, %s",
                                 want.member, member, want.last, last,
                                 $sformatf("overflow exp %0b got %0b", want.ovf, ovf));
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;   // entry_id, entry_parent, root_id, pad
    logic [0:0]         s_axis_tuser;   // req_type
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [MDATA_W-1:0] m_axis_tdata;   // member_id, pad
    logic               m_axis_tlast;   // last_member
    logic [0:0]         m_axis_tuser;   // table_overflowed

    descendant_tracker tracker;
    int  items_done     = 0;
    bit  sender_idles   = 1'b0;
    bit  receiver_idles = 1'b0;
    bit  squeeze_armed  = 1'b0;

    descendant_set_finder_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tlast  (m_axis_tlast),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one item at the falling edge and hold it until the transfer
    task automatic send_item(logic req, t_id id, t_id parent, t_id root);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{(TDATA_W - 3 * ID_W){1'b0}}, root, parent, id};
        do begin
            @(posedge clk);
        end while (!s_axis_tready);
        tracker.take_request(req, id, parent, root);
        items_done++;
        @(negedge clk);
    endtask

    // Unused fields carry random values so their bits toggle too
    task automatic load_pair(t_id id, t_id parent);
        send_item(REQ_LOAD, id, parent, t_id'($urandom_range(0, ID_MAX)));
    endtask

    task automatic query(t_id root);
        send_item(REQ_QUERY, t_id'($urandom_range(0, ID_MAX)),
                  t_id'($urandom_range(0, ID_MAX)), root);
    endtask

    // Result checking at the rising edge
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_member(m_axis_tdata[ID_W-1:0], m_axis_tlast, m_axis_tuser[0]);
    end

    // Receiver: random stall bursts plus one long hold-off
    initial begin
        int hold;
        hold          = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (squeeze_armed && m_axis_tvalid) begin
                squeeze_armed = 1'b0;
                hold          = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                hold          = $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles without any transfer
    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("descendant_set_finder_core test failed");
        $finish;
    end

    // Main stimulus
    initial begin
        int  rand_start;
        int  n;
        int  pick;
        int  tmp;
        int  loads;
        bit  dup;
        bit  chain_done;
        bit  quiet;
        t_id base;
        t_id root;
        int  order[40];
        t_id parent_of[40];

        tracker       = new;
        chain_done    = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_LOAD;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Query on an empty table gives just the root, for root ids 0 and ID_MAX
        query(0);
        query(t_id'(ID_MAX));
        // Chain loaded child first: one addition per pass
        load_pair(7, 6);
        load_pair(6, 5);
        load_pair(5, 0);
        query(0);
        // Root also appears as a table id: not added twice
        load_pair(0, 3);
        load_pair(3, 0);
        query(0);
        // Repeated id in the table: added once
        load_pair(9, 1);
        load_pair(9, 1);
        load_pair(2, 1);
        query(1);
        // Ids 0 and ID_MAX in both pair fields
        load_pair(t_id'(ID_MAX), 0);
        load_pair(0, t_id'(ID_MAX));
        load_pair(12, 0);
        query(t_id'(ID_MAX));

        // Random part
        squeeze_armed = 1'b1;
        rand_start    = items_done;
        while (items_done - rand_start < RANDOM_ITEMS) begin
            quiet          = (items_done - rand_start) >= RANDOM_ITEMS - QUIET_TAIL;
            sender_idles   = !quiet && ($urandom_range(0, 3) != 0);
            receiver_idles = !quiet && ($urandom_range(0, 3) != 0);
            if (!chain_done && items_done - rand_start >= 40) begin
                // Full table as a reversed chain, then loads that overflow
                chain_done = 1'b1;
                base = t_id'($urandom_range(0, ID_MAX - 64));
                for (int j = TABLE_DEPTH; j >= 1; j--)
                    load_pair(t_id'(base + j), t_id'(base + j - 1));
                load_pair(t_id'($urandom_range(0, ID_MAX)), t_id'($urandom_range(0, ID_MAX)));
                load_pair(t_id'(base + TABLE_DEPTH + 1), base);
                query(base);
            end else if ($urandom_range(0, 5) == 0) begin
                // Noise: unrelated pairs, sometimes no query after them
                loads = $urandom_range(0, 4);
                root  = t_id'($urandom_range(0, ID_MAX));
                for (int j = 0; j < loads; j++) begin
                    root = t_id'($urandom_range(0, ID_MAX));
                    load_pair(t_id'($urandom_range(0, ID_MAX)), root);
                end
                if ($urandom_range(0, 2) != 0)
                    query($urandom_range(0, 1) ? root : t_id'($urandom_range(0, ID_MAX)));
            end else begin
                // Random tree below base, loaded in shuffled order
                n    = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16)
                                                   : $urandom_range(0, 8);
                base = t_id'($urandom_range(0, ID_MAX - 64));
                for (int k = 1; k <= n; k++) begin
                    parent_of[k] = t_id'(base + $urandom_range(0, k - 1));
                    order[k - 1] = k;
                end
                for (int k = n - 1; k >= 1; k--) begin
                    pick        = $urandom_range(0, k);
                    tmp         = order[k];
                    order[k]    = order[pick];
                    order[pick] = tmp;
                end
                // broken trees: an orphaned entry or a repeated pair
                if (n > 0 && $urandom_range(0, 5) == 0)
                    parent_of[$urandom_range(1, n)] = t_id'($urandom_range(0, ID_MAX));
                dup = ($urandom_range(0, 5) == 0);
                for (int j = 0; j < n; j++) begin
                    load_pair(t_id'(base + order[j]), parent_of[order[j]]);
                    if (dup && j == 0)
                        load_pair(t_id'(base + order[j]), parent_of[order[j]]);
                end
                case ($urandom_range(0, 9))
                    0:       query(t_id'($urandom_range(0, ID_MAX)));
                    1, 2:    query(t_id'(base + $urandom_range(0, n)));
                    default: query(base);
                endcase
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain and let any stray result show up
        while (tracker.pending_members.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
            $display("descendant_set_finder_core test passed");
        else
            $display("descendant_set_finder_core test failed");
        $finish;
    end

endmodule
